/* rtl/core/rtpe_pkg.sv */
// ----------------------------------------------------------------------------
// rtpe_pkg
// shared constants and types for the rational transfer product evaluator
// ----------------------------------------------------------------------------
package rtpe_pkg;

   localparam int FACTORS_DEF   = 4;
   localparam int TERMS_DEF     = 8;
   localparam int FRAC_BITS_DEF = 16;

   localparam int X_FRAC   = 16;
   localparam int X_W      = 17;
   localparam int COEF_W   = 16;
   localparam int VAL_W    = 48;
   localparam int CNT_W    = 3;
   localparam int FI_W     = 2;
   localparam int PI_W     = 3;
   localparam int ACC_W    = 64;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             div_zero;
      logic             saturated;
   } rsp_type;

endpackage

/* rtl/core/rtpe_if.sv */
// ----------------------------------------------------------------------------
// rtpe_req_if / rtpe_rsp_if / rtpe_csr_if
// valid/ready channels of the evaluator
// ----------------------------------------------------------------------------
interface rtpe_req_if import rtpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [FI_W-1:0]   factor_index;
   logic              which_poly;
   logic [PI_W-1:0]   power_index;
   logic [COEF_W-1:0] coefficient;
   logic [X_W-1:0]    x_value;
   modport source (output valid, cmd, factor_index, which_poly, power_index,
                   coefficient, x_value, input ready);
   modport sink (input valid, cmd, factor_index, which_poly, power_index,
                 coefficient, x_value, output ready);
endinterface

interface rtpe_rsp_if import rtpe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] value;
   logic             div_zero;
   logic             saturated;
   modport source (output valid, value, div_zero, saturated, input ready);
   modport sink (input valid, value, div_zero, saturated, output ready);
endinterface

interface rtpe_csr_if import rtpe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* rtl/core/rational_transfer_product_eval.sv */
// order: a load word is written at its accepting edge; an evaluate word runs, for each active
//   factor, horner steps over the numerator and then the denominator, a divide, a multiply and a
//   clamp (divide and multiply skipped for a zero denominator), then its result is registered
// throughput: loads back to back while idle; an evaluate word holds the input until its result
//   sits in the output register, so a new evaluate word waits for the previous result
// reset: a clearing pass zeroes the whole coefficient memory first; factor_count is 1
// ----------------------------------------------------------------------------
// rational_transfer_product_eval
// product of numerator over denominator polynomials at a point x
// ----------------------------------------------------------------------------
module rational_transfer_product_eval import rtpe_pkg::*; #(
   parameter int FACTORS   = FACTORS_DEF,
   parameter int TERMS     = TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rtpe_req_if.sink   req,
   rtpe_rsp_if.source rsp,
   rtpe_csr_if.sink   csr
);
   localparam int DEPTH = FACTORS * 2 * TERMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam int FW    = (FACTORS > 1) ? $clog2(FACTORS) : 1;
   localparam int FCW   = $clog2(FACTORS + 1);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_HORN  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_SAT   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW:0]       clr_ff, clr_in;
   logic [CNT_W-1:0]  fcount_ff;
   logic [X_W-1:0]    x_ff, x_in;
   logic [FCW-1:0]    fcnt_ff, fcnt_in;
   logic [FW-1:0]     f_ff, f_in;
   logic              poly_ff, poly_in;
   logic [TW:0]       k_ff, k_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  num_ff, num_in;
   logic [ACC_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]  ratio_ff, ratio_in;
   logic [127:0]      mul_ff, mul_in;
   logic [1:0]        mph_ff, mph_in;
   logic              dz_ff, dz_in;
   logic              sat_ff, sat_in;
   logic              div_start;
   logic              div_done;
   logic [ACC_W-1:0]  div_quo;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [COEF_W-1:0] wr_data, rd_data;
   logic [ACC_W+X_W-1:0] hprod;
   logic [31:0]       ma, mb;
   logic [63:0]       pp;
   logic              load_ok;
   logic [FCW-1:0]    fc_eff;

   rtpe_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtpe_div #(.NUM_W(ACC_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff << FRAC_BITS),
      .den   (acc_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.value     = rsp_ff.value;
   assign rsp.div_zero  = rsp_ff.div_zero;
   assign rsp.saturated = rsp_ff.saturated;

   assign load_ok = (32'(req.factor_index) < FACTORS) && (32'(req.power_index) < TERMS);
   assign rd_addr = AW'((32'(f_ff) * 2 + 32'(poly_ff)) * TERMS + 32'(k_ff[TW-1:0]));
   assign hprod   = acc_ff * x_ff;
   assign pp      = 64'(ma) * 64'(mb);

   always_comb begin
      priority if (fcount_ff == '0) begin
         fc_eff = FCW'(1);
      end else if (32'(fcount_ff) > FACTORS) begin
         fc_eff = FCW'(FACTORS);
      end else begin
         fc_eff = FCW'(fcount_ff);
      end
   end

   always_comb begin
      unique case (mph_ff)
         2'd0: begin ma = prod_ff[31:0];  mb = ratio_ff[31:0];  end
         2'd1: begin ma = prod_ff[31:0];  mb = ratio_ff[63:32]; end
         2'd2: begin ma = prod_ff[63:32]; mb = ratio_ff[31:0];  end
         default: begin ma = prod_ff[63:32]; mb = ratio_ff[63:32]; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      fcnt_in      = fcnt_ff;
      f_in         = f_ff;
      poly_in      = poly_ff;
      k_in         = k_ff;
      rd_pend_in   = 1'b0;
      acc_in       = acc_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      ratio_in     = ratio_ff;
      mul_in       = mul_ff;
      mph_in       = mph_ff;
      dz_in        = dz_ff;
      sat_in       = sat_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'((32'(req.factor_index) * 2 + 32'(req.which_poly)) * TERMS
                         + 32'(req.power_index));
      wr_data      = req.coefficient;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.cmd == CMD_LOAD) begin
                  wr_en = load_ok;
               end else begin
                  x_in    = (req.x_value > X_W'(65536)) ? X_W'(65536) : req.x_value;
                  fcnt_in = fc_eff;
                  f_in    = '0;
                  poly_in = 1'b0;
                  k_in    = (TW+1)'(TERMS - 1);
                  acc_in  = '0;
                  prod_in = ACC_W'(1) << FRAC_BITS;
                  dz_in   = 1'b0;
                  sat_in  = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_pend_in = 1'b1;
            state_in   = ST_HORN;
         end
         ST_HORN: begin
            acc_in = ACC_W'(hprod >> X_FRAC) + (ACC_W'(rd_data) << X_FRAC);
            if (k_ff == '0) begin
               k_in = (TW+1)'(TERMS - 1);
               if (!poly_ff) begin
                  num_in   = ACC_W'(hprod >> X_FRAC) + (ACC_W'(rd_data) << X_FRAC);
                  acc_in   = '0;
                  poly_in  = 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (acc_ff == '0) begin
               dz_in    = 1'b1;
               state_in = ST_SAT;
            end else if (!rd_pend_ff && !div_done) begin
               div_start  = 1'b1;
               rd_pend_in = 1'b1;
            end else if (div_done) begin
               ratio_in = (div_quo > 64'(VAL_MAX)) ? 64'(VAL_MAX) : div_quo;
               if (div_quo > 64'(VAL_MAX)) begin
                  sat_in = 1'b1;
               end
               mul_in   = '0;
               mph_in   = 2'd0;
               state_in = ST_MUL;
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         ST_MUL: begin
            unique case (mph_ff)
               2'd0: mul_in = mul_ff + 128'(pp);
               2'd1: mul_in = mul_ff + (128'(pp) << 32);
               2'd2: mul_in = mul_ff + (128'(pp) << 32);
               default: mul_in = mul_ff + (128'(pp) << 64);
            endcase
            mph_in = mph_ff + 1'b1;
            if (mph_ff == 2'd3) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (!dz_ff || acc_ff != '0) begin
               if ((mul_ff >> FRAC_BITS) > 128'(VAL_MAX)) begin
                  prod_in = 64'(VAL_MAX);
                  sat_in  = 1'b1;
               end else begin
                  prod_in = 64'(mul_ff >> FRAC_BITS);
               end
            end
            if (32'(f_ff) + 1 >= 32'(fcnt_ff)) begin
               state_in = ST_OUT;
            end else begin
               f_in     = f_ff + 1'b1;
               poly_in  = 1'b0;
               acc_in   = '0;
               k_in     = (TW+1)'(TERMS - 1);
               state_in = ST_READ;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.value     = dz_ff ? VAL_MAX : prod_ff[VAL_W-1:0];
               rsp_in.div_zero  = dz_ff;
               rsp_in.saturated = dz_ff ? 1'b0 : sat_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fcount_ff    <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr.valid && csr.ready) begin
            fcount_ff <= csr.data;
         end
      end
      x_ff     <= x_in;
      fcnt_ff  <= fcnt_in;
      f_ff     <= f_in;
      poly_ff  <= poly_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      ratio_ff <= ratio_in;
      mul_ff   <= mul_in;
      mph_ff   <= mph_in;
      dz_ff    <= dz_in;
      sat_ff   <= sat_in;
      rsp_ff   <= rsp_in;
   end
endmodule

/* rtl/core/rtpe_ram.sv */
// ----------------------------------------------------------------------------
// rtpe_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module rtpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/rtpe_div.sv */
// ----------------------------------------------------------------------------
// rtpe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtpe_div import rtpe_pkg::*; #(
   parameter int NUM_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [NUM_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[NUM_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* rtl/core/rtpe_checker.sv */
// ----------------------------------------------------------------------------
// rtpe_checker
// port level checks of the evaluator
// ----------------------------------------------------------------------------
module rtpe_checker import rtpe_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_cmd,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [VAL_W-1:0] rsp_value,
   input logic             rsp_div_zero,
   input logic             rsp_saturated
);
   a_dz_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_value == VAL_MAX && !rsp_saturated)
      else $error("div_zero word without max value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response word dropped");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_div_zero) && $stable(rsp_saturated))
      else $error("response flags changed while waiting");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load gave a response");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response out of reset");
endmodule

bind rational_transfer_product_eval rtpe_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_cmd       (req.cmd),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_value     (rsp.value),
   .rsp_div_zero  (rsp.div_zero),
   .rsp_saturated (rsp.saturated)
);
